// ===== hdl/ica_pkg.sv =====
// Shared types, codes and constants of the integer calculator ALU.
package ica_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int MODE_W = 3;
    localparam int STATUS_W = 2;
    // Counter holds a bit index of a division and factorial steps up to FACT_ZERO_FROM.
    localparam int CNT_W = 6;
    // 34! holds 32 factors of two, so every factorial from here on wraps to zero.
    localparam int FACT_ZERO_FROM = 34;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD     = 3'd0,
        MODE_SUB     = 3'd1,
        MODE_MUL     = 3'd2,
        MODE_DIV     = 3'd3,
        MODE_POW     = 3'd4,
        MODE_SQRT    = 3'd5,
        MODE_FACT    = 3'd6,
        MODE_INVALID = 3'd7
    } ica_mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_DIVZERO = 2'd1,
        ST_NEG     = 2'd2,
        ST_INVALID = 2'd3
    } ica_status_t;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2
    } ica_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_FIX,
        S_POW_MUL,
        S_POW_SQR,
        S_SQRT,
        S_FACT,
        S_DONE
    } ica_state_t;

    // request to the shared arithmetic unit
    typedef struct packed {
        ica_op_t               op;
        logic [DATA_WIDTH-1:0] x;
        logic [DATA_WIDTH-1:0] y;
    } ica_req_t;

    // answer of the shared arithmetic unit
    typedef struct packed {
        logic [DATA_WIDTH-1:0] value;
        logic                  borrow;
    } ica_rsp_t;

endpackage

// ===== hdl/ica_unit.sv =====
// Shared arithmetic unit: add, subtract with borrow, low-half multiply.
module ica_unit (
    input  ica_pkg::ica_req_t req,
    output ica_pkg::ica_rsp_t rsp
);

    logic [ica_pkg::DATA_WIDTH:0]     diff;
    logic [2*ica_pkg::DATA_WIDTH-1:0] prod;

    assign diff = {1'b0, req.x} - {1'b0, req.y};
    assign prod = req.x * req.y;

    always_comb
    begin
        rsp.borrow = diff[ica_pkg::DATA_WIDTH];
        case (req.op)
            ica_pkg::OP_ADD: rsp.value = req.x + req.y;
            ica_pkg::OP_SUB: rsp.value = diff[ica_pkg::DATA_WIDTH-1:0];
            ica_pkg::OP_MUL: rsp.value = prod[ica_pkg::DATA_WIDTH-1:0];
            default:         rsp.value = '0;
        endcase
    end

endmodule

// ===== hdl/ica_seq.sv =====
// Sequencer: decodes a word, drives the shared unit step by step, holds the answer.
module ica_seq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ica_pkg::MODE_W-1:0]        mode,
    input  logic [ica_pkg::DATA_WIDTH-1:0]    operand_a,
    input  logic [ica_pkg::DATA_WIDTH-1:0]    operand_b,
    output logic                              done_valid,
    input  logic                              done_ready,
    output logic [ica_pkg::DATA_WIDTH-1:0]    result,
    output logic [ica_pkg::STATUS_W-1:0]      status,
    output ica_pkg::ica_req_t                 req,
    input  ica_pkg::ica_rsp_t                 rsp
);

    localparam int W = ica_pkg::DATA_WIDTH;
    localparam logic [W-1:0] ONE = W'(1);
    localparam logic [W-1:0] SQRT_TOP = {2'b01, {(W-2){1'b0}}};

    ica_pkg::ica_state_t  state_reg, state_next;
    ica_pkg::ica_mode_t   mode_reg, mode_next;
    ica_pkg::ica_status_t status_reg, status_next;
    logic [W-1:0]         a_reg, a_next;
    logic [W-1:0]         b_reg, b_next;
    logic [W-1:0]         acc_reg, acc_next;
    logic [W-1:0]         rem_reg, rem_next;
    logic [W-1:0]         res_reg, res_next;
    logic [ica_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [ica_pkg::CNT_W-1:0] lim_reg, lim_next;
    logic                 neg_reg, neg_next;
    logic [W-1:0]         abs_a, abs_b, sqrt_acc;

    assign abs_a = operand_a[W-1] ? (~operand_a + ONE) : operand_a;
    assign abs_b = operand_b[W-1] ? (~operand_b + ONE) : operand_b;
    assign sqrt_acc = rsp.borrow ? (acc_reg >> 1) : ((acc_reg >> 1) | b_reg);

    assign result = res_reg;
    assign status = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ica_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        status_reg <= status_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        res_reg    <= res_next;
        cnt_reg    <= cnt_next;
        lim_reg    <= lim_next;
        neg_reg    <= neg_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        status_next = status_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        res_next    = res_reg;
        cnt_next    = cnt_reg;
        lim_next    = lim_reg;
        neg_next    = neg_reg;
        in_ready    = 1'b0;
        done_valid  = 1'b0;
        req.op      = ica_pkg::OP_ADD;
        req.x       = '0;
        req.y       = '0;

        case (state_reg)
            ica_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    mode_next   = ica_pkg::ica_mode_t'(mode);
                    status_next = ica_pkg::ST_OK;
                    res_next    = '0;
                    state_next  = ica_pkg::S_DONE;
                    case (ica_pkg::ica_mode_t'(mode))
                        ica_pkg::MODE_ADD, ica_pkg::MODE_SUB, ica_pkg::MODE_MUL:
                        begin
                            req.op = (ica_pkg::ica_mode_t'(mode) == ica_pkg::MODE_ADD)
                                   ? ica_pkg::OP_ADD
                                   : (ica_pkg::ica_mode_t'(mode) == ica_pkg::MODE_SUB)
                                   ? ica_pkg::OP_SUB : ica_pkg::OP_MUL;
                            req.x    = operand_a;
                            req.y    = operand_b;
                            res_next = rsp.value;
                        end
                        ica_pkg::MODE_DIV:
                        begin
                            if (operand_b == '0)
                            begin
                                status_next = ica_pkg::ST_DIVZERO;
                            end
                            else
                            begin
                                a_next     = abs_a;
                                b_next     = abs_b;
                                rem_next   = '0;
                                neg_next   = operand_a[W-1] ^ operand_b[W-1];
                                cnt_next   = ica_pkg::CNT_W'(W - 1);
                                state_next = ica_pkg::S_DIV;
                            end
                        end
                        ica_pkg::MODE_POW:
                        begin
                            if (operand_b[W-1])
                            begin
                                // negative exponent: only bases of zero and plus or minus one matter
                                if (operand_a == '0)
                                    status_next = ica_pkg::ST_DIVZERO;
                                else if (operand_a == ONE)
                                    res_next = ONE;
                                else if (operand_a == '1)
                                    res_next = operand_b[0] ? '1 : ONE;
                            end
                            else
                            begin
                                acc_next   = ONE;
                                a_next     = operand_a;
                                b_next     = operand_b;
                                state_next = ica_pkg::S_POW_MUL;
                            end
                        end
                        ica_pkg::MODE_SQRT:
                        begin
                            if (operand_a[W-1])
                            begin
                                status_next = ica_pkg::ST_NEG;
                            end
                            else
                            begin
                                a_next     = operand_a;
                                acc_next   = '0;
                                b_next     = SQRT_TOP;
                                state_next = ica_pkg::S_SQRT;
                            end
                        end
                        ica_pkg::MODE_FACT:
                        begin
                            if (operand_a[W-1])
                                status_next = ica_pkg::ST_NEG;
                            else if (operand_a < W'(ica_pkg::FACT_ZERO_FROM))
                            begin
                                acc_next   = ONE;
                                lim_next   = operand_a[ica_pkg::CNT_W-1:0];
                                cnt_next   = ica_pkg::CNT_W'(2);
                                state_next = ica_pkg::S_FACT;
                            end
                        end
                        default:
                        begin
                            status_next = ica_pkg::ST_INVALID;
                        end
                    endcase
                end
            end

            ica_pkg::S_DIV:
            begin
                // restoring division, one quotient bit a cycle into a_reg
                req.op = ica_pkg::OP_SUB;
                req.x  = {rem_reg[W-2:0], a_reg[W-1]};
                req.y  = b_reg;
                rem_next = rsp.borrow ? req.x : rsp.value;
                a_next   = {a_reg[W-2:0], ~rsp.borrow};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ica_pkg::S_FIX;
            end

            ica_pkg::S_FIX:
            begin
                req.op     = ica_pkg::OP_SUB;
                req.x      = '0;
                req.y      = a_reg;
                res_next   = neg_reg ? rsp.value : a_reg;
                state_next = ica_pkg::S_DONE;
            end

            ica_pkg::S_POW_MUL:
            begin
                req.op = ica_pkg::OP_MUL;
                req.x  = acc_reg;
                req.y  = a_reg;
                if (b_reg == '0)
                begin
                    res_next   = acc_reg;
                    state_next = ica_pkg::S_DONE;
                end
                else
                begin
                    if (b_reg[0])
                        acc_next = rsp.value;
                    state_next = ica_pkg::S_POW_SQR;
                end
            end

            ica_pkg::S_POW_SQR:
            begin
                req.op     = ica_pkg::OP_MUL;
                req.x      = a_reg;
                req.y      = a_reg;
                a_next     = rsp.value;
                b_next     = b_reg >> 1;
                state_next = ica_pkg::S_POW_MUL;
            end

            ica_pkg::S_SQRT:
            begin
                // root and trial bit never overlap, so their sum is an OR
                req.op   = ica_pkg::OP_SUB;
                req.x    = a_reg;
                req.y    = acc_reg | b_reg;
                if (!rsp.borrow)
                    a_next = rsp.value;
                acc_next = sqrt_acc;
                b_next   = b_reg >> 2;
                if (b_reg[0])
                begin
                    res_next   = sqrt_acc;
                    state_next = ica_pkg::S_DONE;
                end
            end

            ica_pkg::S_FACT:
            begin
                req.op = ica_pkg::OP_MUL;
                req.x  = acc_reg;
                req.y  = W'(cnt_reg);
                if (cnt_reg > lim_reg)
                begin
                    res_next   = acc_reg;
                    state_next = ica_pkg::S_DONE;
                end
                else
                begin
                    acc_next = rsp.value;
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ica_pkg::S_DONE:
            begin
                done_valid = 1'b1;
                if (done_ready)
                    state_next = ica_pkg::S_IDLE;
            end

            default:
            begin
                state_next = ica_pkg::S_IDLE;
            end
        endcase
    end

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_valid && (status_reg != ica_pkg::ST_OK) |-> (res_reg == '0))
        else $error("error word carries a nonzero result");

    a_divzero_src: assert property (@(posedge clk) disable iff (!rst_n)
        done_valid && (status_reg == ica_pkg::ST_DIVZERO)
        |-> (mode_reg == ica_pkg::MODE_DIV || mode_reg == ica_pkg::MODE_POW))
        else $error("divide-by-zero status from an operation that cannot divide");

    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ica_pkg::S_DIV) && (cnt_reg == '0) |=> (state_reg == ica_pkg::S_FIX))
        else $error("division did not finish after its last quotient bit");

    a_sqrt_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ica_pkg::S_SQRT) |-> $onehot(b_reg))
        else $error("square root trial bit lost its single set bit");

endmodule

// ===== hdl/integer_calculator_alu.sv =====
// Top level of the multicycle integer calculator ALU.
//
// Input channel s_axis: one word carries an operation in tuser and two signed 32-bit
// operands in tdata. Output channel m_axis: one word carries the 32-bit result in tdata
// and a status in tuser (ok, divide by zero, negative operand, invalid mode).
// Every input word gives exactly one output word, in order.
//
// Work per operation, from the word taken to its result on m_axis:
//   add, sub, mul, errors, negative exponents, factorial of 34 and up: set when taken
//   divide: one quotient bit a cycle, then a sign fix-up
//   square root: one root bit, two radicand bits a cycle
//   power: square and multiply, a multiply step and a squaring step per exponent bit
//   factorial of n below 34: one multiply per factor from 2 to n
// All long operations run through one shared add/subtract/multiply unit under the
// sequencer, so only one word is in work at a time and s_axis_tready is low meanwhile.
// Reset clears the sequencer and empties the output register.
// When the receiver stalls, the finished word waits in the output register and the
// block takes and works on the next input word; it then waits for the register to drain.
module integer_calculator_alu (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // operand_a [31:0], operand_b [63:32]
    input  logic [2:0]  s_axis_tuser,   // mode [2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // result [31:0]
    output logic [1:0]  m_axis_tuser    // status [1:0]
);

    localparam int W = ica_pkg::DATA_WIDTH;

    ica_pkg::ica_req_t req;
    ica_pkg::ica_rsp_t rsp;

    logic                         done_valid;
    logic                         done_ready;
    logic [W-1:0]                 seq_result;
    logic [ica_pkg::STATUS_W-1:0] seq_status;

    logic                         out_valid_reg, out_valid_next;
    logic [W-1:0]                 out_data_reg, out_data_next;
    logic [ica_pkg::STATUS_W-1:0] out_user_reg, out_user_next;

    ica_unit u_unit (
        .req (req),
        .rsp (rsp)
    );

    ica_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .mode       (s_axis_tuser),
        .operand_a  (s_axis_tdata[31:0]),
        .operand_b  (s_axis_tdata[63:32]),
        .done_valid (done_valid),
        .done_ready (done_ready),
        .result     (seq_result),
        .status     (seq_status),
        .req        (req),
        .rsp        (rsp)
    );

    // output register: free when empty or being drained this cycle
    assign done_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        if (done_ready)
        begin
            out_valid_next = done_valid;
            if (done_valid)
            begin
                out_data_next = seq_result;
                out_user_next = seq_status;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule
